>>> src/mcs_pkg.sv
`default_nettype none
package mcs_pkg;

    localparam int SIDE_W  = 15;
    localparam int LVL_W   = 4;
    localparam int FMT_W   = 4;
    localparam int KIND_W  = 2;
    localparam int AREA_W  = 30;
    localparam int IMG_W   = 33;
    localparam int PROD_W  = 48;
    localparam int ACC_W   = 50;
    localparam int SCL_W   = 53;
    localparam int TOTAL_W = 48;

    localparam int MAX_SIDE_LOG2_DEF = 14;

    localparam logic [KIND_W-1:0] KIND_VOLUME = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CUBE   = 2'd2;

    localparam logic [FMT_W-1:0] FMT_R8       = 4'd0;
    localparam logic [FMT_W-1:0] FMT_P16A     = 4'd1;
    localparam logic [FMT_W-1:0] FMT_P16B     = 4'd2;
    localparam logic [FMT_W-1:0] FMT_P32A     = 4'd3;
    localparam logic [FMT_W-1:0] FMT_P32B     = 4'd4;
    localparam logic [FMT_W-1:0] FMT_P64      = 4'd5;
    localparam logic [FMT_W-1:0] FMT_BC1      = 4'd6;
    localparam logic [FMT_W-1:0] FMT_BC2      = 4'd7;
    localparam logic [FMT_W-1:0] FMT_BC3      = 4'd8;
    localparam logic [FMT_W-1:0] FMT_PVRTC2A  = 4'd9;
    localparam logic [FMT_W-1:0] FMT_PVRTC2B  = 4'd10;
    localparam logic [FMT_W-1:0] FMT_PVRTC4A  = 4'd11;
    localparam logic [FMT_W-1:0] FMT_PVRTC4B  = 4'd12;
    localparam logic [FMT_W-1:0] FMT_ETC1     = 4'd13;
    localparam logic [FMT_W-1:0] FMT_DEPTH16  = 4'd14;
    localparam logic [FMT_W-1:0] FMT_DEPTH32  = 4'd15;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_XY,
        S_D,
        S_FIN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              en;
        logic [IMG_W-1:0]  a;
        logic [SIDE_W-1:0] b;
    } mul_req_t;

    // Left shift that turns width times height into bytes for plain and depth formats.
    function automatic logic [1:0] plain_shift(input logic [FMT_W-1:0] fmt);
        logic [1:0] s;
        begin
            s = 2'd0;
            case (fmt) inside
                FMT_P16A, FMT_P16B, FMT_DEPTH16: s = 2'd1;
                FMT_P32A, FMT_P32B, FMT_DEPTH32: s = 2'd2;
                FMT_P64:                         s = 2'd3;
                default:                         s = 2'd0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [SIDE_W-1:0] level_side(input logic [SIDE_W-1:0] side,
                                                     input logic [LVL_W-1:0]  lvl);
        logic [SIDE_W-1:0] s;
        begin
            s = side >> lvl;
            return (s == '0) ? SIDE_W'(1) : s;
        end
    endfunction

    // Number of halvings until the value reaches zero.
    function automatic logic [LVL_W-1:0] bit_length(input logic [SIDE_W-1:0] v);
        logic [LVL_W-1:0] n;
        begin
            n = '0;
            for (int i = 0; i < SIDE_W; i++) begin
                if (v[i]) begin
                    n = LVL_W'(i + 1);
                end
            end
            return n;
        end
    endfunction

endpackage
`default_nettype wire

>>> src/texture_mip_chain_size_top.sv
// Channel  | Signals                                             | Handshake
// ---------+-----------------------------------------------------+-----------------------------
// request  | kind, format_code, width_px, height_px, depth_px,   | taken when start & !busy
//          | mip_count                                           |
// result   | total_bytes, max_mips, invalid                      | one cycle, marked by done
//
// A request with mip_count N steps through S_XY and S_D once per level, then S_FIN and S_OUT,
// before done is strobed; each level uses the single shared 33x15 multiplier in S_XY and S_D.
// busy is high for the whole computation; a new request may be taken in the cycle done is high.
// rst_n is asynchronous and active low and returns the sequencer to idle.
// The receiver cannot stall: each result is presented for exactly one cycle.
`default_nettype none
module texture_mip_chain_size_top #(
    parameter int MAX_SIDE_LOG2 = mcs_pkg::MAX_SIDE_LOG2_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [mcs_pkg::KIND_W-1:0]    kind,
    input  wire logic [mcs_pkg::FMT_W-1:0]     format_code,
    input  wire logic [mcs_pkg::SIDE_W-1:0]    width_px,
    input  wire logic [mcs_pkg::SIDE_W-1:0]    height_px,
    input  wire logic [mcs_pkg::SIDE_W-1:0]    depth_px,
    input  wire logic [mcs_pkg::LVL_W-1:0]     mip_count,
    output logic                               done,
    output logic [mcs_pkg::TOTAL_W-1:0]        total_bytes,
    output logic [mcs_pkg::LVL_W-1:0]          max_mips,
    output logic                               invalid
);

    mcs_pkg::mul_req_t          mul_req;
    logic [mcs_pkg::PROD_W-1:0] prod;

    mcs_ctrl #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .format_code (format_code),
        .width_px    (width_px),
        .height_px   (height_px),
        .depth_px    (depth_px),
        .mip_count   (mip_count),
        .prod        (prod),
        .mul_req     (mul_req),
        .busy        (busy),
        .done        (done),
        .total_bytes (total_bytes),
        .max_mips    (max_mips),
        .invalid     (invalid)
    );

    mcs_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

endmodule
`default_nettype wire

>>> src/mcs_mul.sv
`default_nettype none
module mcs_mul (
    input  wire logic                        clk,
    input  wire mcs_pkg::mul_req_t           req,
    output logic [mcs_pkg::PROD_W-1:0]       prod
);

    logic [mcs_pkg::PROD_W-1:0] prod_reg;
    logic [mcs_pkg::PROD_W-1:0] prod_next;

    // Operand a stays below 2^33 and b below 2^15, so the product fits in 48 bits.
    assign prod_next = mcs_pkg::PROD_W'(req.a) * mcs_pkg::PROD_W'(req.b);

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

>>> src/mcs_ctrl.sv
`default_nettype none
module mcs_ctrl #(
    parameter int MAX_SIDE_LOG2 = mcs_pkg::MAX_SIDE_LOG2_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mcs_pkg::KIND_W-1:0]    kind,
    input  wire logic [mcs_pkg::FMT_W-1:0]     format_code,
    input  wire logic [mcs_pkg::SIDE_W-1:0]    width_px,
    input  wire logic [mcs_pkg::SIDE_W-1:0]    height_px,
    input  wire logic [mcs_pkg::SIDE_W-1:0]    depth_px,
    input  wire logic [mcs_pkg::LVL_W-1:0]     mip_count,
    input  wire logic [mcs_pkg::PROD_W-1:0]    prod,
    output mcs_pkg::mul_req_t                  mul_req,
    output logic                               busy,
    output logic                               done,
    output logic [mcs_pkg::TOTAL_W-1:0]        total_bytes,
    output logic [mcs_pkg::LVL_W-1:0]          max_mips,
    output logic                               invalid
);

    localparam logic [31:0] SIDE_LIMIT = 32'd1 << MAX_SIDE_LOG2;

    mcs_pkg::state_t state_reg, state_next;
    logic [mcs_pkg::LVL_W-1:0]   m_reg, m_next;
    logic                        done_reg, done_next;

    logic [mcs_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [mcs_pkg::FMT_W-1:0]   fmt_reg, fmt_next;
    logic [mcs_pkg::SIDE_W-1:0]  w_reg, w_next;
    logic [mcs_pkg::SIDE_W-1:0]  h_reg, h_next;
    logic [mcs_pkg::SIDE_W-1:0]  d_reg, d_next;
    logic [mcs_pkg::LVL_W-1:0]   mips_reg, mips_next;
    logic [mcs_pkg::LVL_W-1:0]   maxm_reg, maxm_next;
    logic                        bad_reg, bad_next;
    logic [mcs_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [mcs_pkg::TOTAL_W-1:0] total_reg, total_next;

    logic [mcs_pkg::SIDE_W-1:0]  ws, hs, ds;
    logic [mcs_pkg::SIDE_W-1:0]  bw, bh;
    logic [mcs_pkg::SIDE_W:0]    w_round, h_round;
    logic [mcs_pkg::AREA_W-1:0]  area;
    logic [mcs_pkg::IMG_W-1:0]   img;
    logic [mcs_pkg::ACC_W-1:0]   acc_sum;
    logic [mcs_pkg::SCL_W-1:0]   scaled;
    logic [mcs_pkg::LVL_W-1:0]   in_maxm;
    logic                        in_bad;
    logic                        last_lvl;

    assign ws = mcs_pkg::level_side(w_reg, m_reg);
    assign hs = mcs_pkg::level_side(h_reg, m_reg);
    assign ds = mcs_pkg::level_side(d_reg, m_reg);

    assign w_round = ({1'b0, ws} + (mcs_pkg::SIDE_W+1)'(3)) >> 2;
    assign h_round = ({1'b0, hs} + (mcs_pkg::SIDE_W+1)'(3)) >> 2;

    // First pass of a level: the extents after block rounding or PVRTC minimums.
    always_comb
    begin
        bw = ws;
        bh = hs;
        case (fmt_reg) inside
            mcs_pkg::FMT_BC1, mcs_pkg::FMT_BC2, mcs_pkg::FMT_BC3, mcs_pkg::FMT_ETC1:
            begin
                bw = w_round[mcs_pkg::SIDE_W-1:0];
                bh = h_round[mcs_pkg::SIDE_W-1:0];
            end
            mcs_pkg::FMT_PVRTC2A, mcs_pkg::FMT_PVRTC2B:
            begin
                bw = (ws < mcs_pkg::SIDE_W'(16)) ? mcs_pkg::SIDE_W'(16) : ws;
                bh = (hs < mcs_pkg::SIDE_W'(8))  ? mcs_pkg::SIDE_W'(8)  : hs;
            end
            mcs_pkg::FMT_PVRTC4A, mcs_pkg::FMT_PVRTC4B:
            begin
                bw = (ws < mcs_pkg::SIDE_W'(8)) ? mcs_pkg::SIDE_W'(8) : ws;
                bh = (hs < mcs_pkg::SIDE_W'(8)) ? mcs_pkg::SIDE_W'(8) : hs;
            end
            default:
            begin
                bw = ws;
                bh = hs;
            end
        endcase
    end

    // The PVRTC byte rounding reduces to a ceiling of the area over four or two.
    assign area = prod[mcs_pkg::AREA_W-1:0];

    always_comb
    begin
        img = '0;
        case (fmt_reg) inside
            mcs_pkg::FMT_BC1, mcs_pkg::FMT_ETC1:
                img = mcs_pkg::IMG_W'(area) << 3;
            mcs_pkg::FMT_BC2, mcs_pkg::FMT_BC3:
                img = mcs_pkg::IMG_W'(area) << 4;
            mcs_pkg::FMT_PVRTC2A, mcs_pkg::FMT_PVRTC2B:
                img = (mcs_pkg::IMG_W'(area) + mcs_pkg::IMG_W'(3)) >> 2;
            mcs_pkg::FMT_PVRTC4A, mcs_pkg::FMT_PVRTC4B:
                img = (mcs_pkg::IMG_W'(area) + mcs_pkg::IMG_W'(1)) >> 1;
            default:
                img = mcs_pkg::IMG_W'(area) << mcs_pkg::plain_shift(fmt_reg);
        endcase
    end

    assign acc_sum  = acc_reg + mcs_pkg::ACC_W'(prod);
    assign scaled   = (kind_reg == mcs_pkg::KIND_CUBE)
                    ? ((mcs_pkg::SCL_W'(acc_reg) << 2) + (mcs_pkg::SCL_W'(acc_reg) << 1))
                    : mcs_pkg::SCL_W'(acc_reg);
    assign last_lvl = (m_reg == mcs_pkg::LVL_W'(mips_reg - mcs_pkg::LVL_W'(1)));

    assign in_maxm = mcs_pkg::bit_length(width_px | height_px | depth_px);
    assign in_bad  = (width_px == '0) || (height_px == '0) || (depth_px == '0)
                  || (mip_count == '0) || (mip_count > in_maxm)
                  || ((kind != mcs_pkg::KIND_VOLUME) && (depth_px != mcs_pkg::SIDE_W'(1)))
                  || (32'(width_px) > SIDE_LIMIT) || (32'(height_px) > SIDE_LIMIT)
                  || (32'(depth_px) > SIDE_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        done_next  = 1'b0;
        kind_next  = kind_reg;
        fmt_next   = fmt_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        d_next     = d_reg;
        mips_next  = mips_reg;
        maxm_next  = maxm_reg;
        bad_next   = bad_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        mul_req    = '0;
        unique case (state_reg)
            mcs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    fmt_next   = format_code;
                    w_next     = width_px;
                    h_next     = height_px;
                    d_next     = depth_px;
                    mips_next  = mip_count;
                    maxm_next  = in_maxm;
                    bad_next   = in_bad;
                    acc_next   = '0;
                    m_next     = '0;
                    state_next = (mip_count == '0) ? mcs_pkg::S_OUT : mcs_pkg::S_XY;
                end
            end
            mcs_pkg::S_XY:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = mcs_pkg::IMG_W'(bw);
                mul_req.b  = bh;
                // The previous level's product is folded in while this level's area forms.
                if (m_reg != '0)
                begin
                    acc_next = acc_sum;
                end
                state_next = mcs_pkg::S_D;
            end
            mcs_pkg::S_D:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = img;
                mul_req.b  = ds;
                if (last_lvl)
                begin
                    state_next = mcs_pkg::S_FIN;
                end
                else
                begin
                    m_next     = m_reg + mcs_pkg::LVL_W'(1);
                    state_next = mcs_pkg::S_XY;
                end
            end
            mcs_pkg::S_FIN:
            begin
                acc_next   = acc_sum;
                state_next = mcs_pkg::S_OUT;
            end
            mcs_pkg::S_OUT:
            begin
                total_next = (scaled > mcs_pkg::SCL_W'(mcs_pkg::TOTAL_MAX))
                           ? mcs_pkg::TOTAL_MAX : scaled[mcs_pkg::TOTAL_W-1:0];
                done_next  = 1'b1;
                state_next = mcs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mcs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcs_pkg::S_IDLE;
            m_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            m_reg     <= m_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        fmt_reg   <= fmt_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        d_reg     <= d_next;
        mips_reg  <= mips_next;
        maxm_reg  <= maxm_next;
        bad_reg   <= bad_next;
        acc_reg   <= acc_next;
        total_reg <= total_next;
    end

    assign busy        = (state_reg != mcs_pkg::S_IDLE);
    assign done        = done_reg;
    assign total_bytes = total_reg;
    assign max_mips    = maxm_reg;
    assign invalid     = bad_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcs_pkg::S_OUT) |=> done)
        else $error("final step gave no result strobe");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mcs_pkg::S_XY) || (state_reg == mcs_pkg::S_D)) |-> (m_reg < mips_reg))
        else $error("level index ran past the mip count");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");
`endif

endmodule
`default_nettype wire

>>> tb/mip_size_checker.sv
module mip_size_checker #(
    parameter int MAX_SIDE_LOG2 = mcs_pkg::MAX_SIDE_LOG2_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [mcs_pkg::KIND_W-1:0]     kind,
    input  logic [mcs_pkg::FMT_W-1:0]      format_code,
    input  logic [mcs_pkg::SIDE_W-1:0]     width_px,
    input  logic [mcs_pkg::SIDE_W-1:0]     height_px,
    input  logic [mcs_pkg::SIDE_W-1:0]     depth_px,
    input  logic [mcs_pkg::LVL_W-1:0]      mip_count,
    input  logic                           done,
    input  logic [mcs_pkg::TOTAL_W-1:0]    total_bytes,
    input  logic [mcs_pkg::LVL_W-1:0]      max_mips,
    input  logic                           invalid,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mcs_pkg::*;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [LVL_W-1:0]   levels;
        logic               bad;
    } chain_size_t;

    chain_size_t sizes_due[$];
    int          fail_tally;

    function automatic longint unsigned level_extent(input logic [SIDE_W-1:0] side,
                                                     input int lvl);
        longint unsigned s;
        s = longint'(side) >> lvl;
        return (s == 0) ? 1 : s;
    endfunction

    function automatic longint unsigned level_bytes(input logic [FMT_W-1:0] fmt,
                                                    input longint unsigned w,
                                                    input longint unsigned h);
        longint unsigned blocks;
        longint unsigned pw2;
        longint unsigned pw4;
        longint unsigned ph;
        blocks = ((w + 3) / 4) * ((h + 3) / 4);
        pw2    = (w < 16) ? 16 : w;
        pw4    = (w < 8) ? 8 : w;
        ph     = (h < 8) ? 8 : h;
        case (fmt)
            FMT_BC1, FMT_ETC1:                 return blocks * 8;
            FMT_BC2, FMT_BC3:                  return blocks * 16;
            FMT_PVRTC2A, FMT_PVRTC2B:          return (pw2 * ph * 2 + 7) / 8;
            FMT_PVRTC4A, FMT_PVRTC4B:          return (pw4 * ph * 4 + 7) / 8;
            FMT_P16A, FMT_P16B, FMT_DEPTH16:   return w * h * 2;
            FMT_P32A, FMT_P32B, FMT_DEPTH32:   return w * h * 4;
            FMT_P64:                           return w * h * 8;
            default:                           return w * h;
        endcase
    endfunction

    function automatic chain_size_t predict_chain(input logic [KIND_W-1:0] k,
                                                  input logic [FMT_W-1:0]  fmt,
                                                  input logic [SIDE_W-1:0] w,
                                                  input logic [SIDE_W-1:0] h,
                                                  input logic [SIDE_W-1:0] d,
                                                  input logic [LVL_W-1:0]  mips);
        longint unsigned sum;
        int              levels;
        int              side_cap;
        logic [SIDE_W-1:0] rest;
        chain_size_t     r;
        side_cap = 1 << MAX_SIDE_LOG2;
        // All three sides reach zero once the widest of them has.
        rest   = w | h | d;
        levels = 0;
        while (rest != '0)
        begin
            levels++;
            rest = rest >> 1;
        end
        sum = 0;
        for (int m = 0; m < int'(mips); m++)
        begin
            sum += level_bytes(fmt, level_extent(w, m), level_extent(h, m))
                   * level_extent(d, m);
        end
        if (k == KIND_CUBE)
        begin
            sum = sum * 6;
        end
        if (sum > longint'(TOTAL_MAX))
        begin
            sum = longint'(TOTAL_MAX);
        end
        r.total  = sum[TOTAL_W-1:0];
        r.levels = levels[LVL_W-1:0];
        r.bad    = (w == '0) || (h == '0) || (d == '0)
                   || (mips == '0) || (int'(mips) > levels)
                   || (k != KIND_VOLUME && d != SIDE_W'(1))
                   || (int'(w) > side_cap) || (int'(h) > side_cap) || (int'(d) > side_cap);
        return r;
    endfunction

    always @(posedge clk)
    begin
        chain_size_t want;
        if (!rst_n)
        begin
            sizes_due.delete();
            fail_tally = 0;
        end
        else
        begin
            // A result always belongs to an older request than one taken at the same edge.
            if (done)
            begin
                if (sizes_due.size() == 0)
                begin
                    $error("result with no request outstanding: total_bytes %0d", total_bytes);
                    fail_tally++;
                end
                else
                begin
                    want = sizes_due.pop_front();
                    if (total_bytes !== want.total)
                    begin
                        $error("total_bytes: expected %0d, got %0d", want.total, total_bytes);
                        fail_tally++;
                    end
                    if (max_mips !== want.levels)
                    begin
                        $error("max_mips: expected %0d, got %0d", want.levels, max_mips);
                        fail_tally++;
                    end
                    if (invalid !== want.bad)
                    begin
                        $error("invalid: expected %0b, got %0b", want.bad, invalid);
                        fail_tally++;
                    end
                end
            end
            if (start && !busy)
            begin
                sizes_due.push_back(predict_chain(kind, format_code, width_px, height_px,
                                                  depth_px, mip_count));
            end
        end
        errors  <= fail_tally;
        pending <= sizes_due.size();
    end

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int STALL_LIMIT    = 1000;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_REQUESTS = 467;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [KIND_W-1:0]   kind;
    logic [FMT_W-1:0]    format_code;
    logic [SIDE_W-1:0]   width_px;
    logic [SIDE_W-1:0]   height_px;
    logic [SIDE_W-1:0]   depth_px;
    logic [LVL_W-1:0]    mip_count;
    logic                done;
    logic [TOTAL_W-1:0]  total_bytes;
    logic [LVL_W-1:0]    max_mips;
    logic                invalid;
    int                  errors;
    int                  pending;
    int                  idle_pct;
    int                  quiet_cycles;

    texture_mip_chain_size_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .format_code (format_code),
        .width_px    (width_px),
        .height_px   (height_px),
        .depth_px    (depth_px),
        .mip_count   (mip_count),
        .done        (done),
        .total_bytes (total_bytes),
        .max_mips    (max_mips),
        .invalid     (invalid)
    );

    mip_size_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .format_code (format_code),
        .width_px    (width_px),
        .height_px   (height_px),
        .depth_px    (depth_px),
        .mip_count   (mip_count),
        .done        (done),
        .total_bytes (total_bytes),
        .max_mips    (max_mips),
        .invalid     (invalid),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The request stays up while the block is busy; gaps are only inserted between requests.
    task automatic issue_request(input logic [KIND_W-1:0] k, input logic [FMT_W-1:0] f,
                                 input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                                 input logic [SIDE_W-1:0] d, input logic [LVL_W-1:0] m);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= k;
        format_code <= f;
        width_px    <= w;
        height_px   <= h;
        depth_px    <= d;
        mip_count   <= m;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [SIDE_W-1:0] legal_side();
        int v;
        if ($urandom_range(19) == 0)
        begin
            return SIDE_W'(1 << MAX_SIDE_LOG2_DEF);
        end
        v = $urandom_range(1, 1 << MAX_SIDE_LOG2_DEF) >> $urandom_range(0, 14);
        return (v == 0) ? SIDE_W'(1) : SIDE_W'(v);
    endfunction

    task automatic random_request();
        logic [KIND_W-1:0] k;
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic [SIDE_W-1:0] d;
        logic [SIDE_W-1:0] rest;
        int                halvings;
        if ($urandom_range(99) < 80)
        begin
            // Well-formed texture with a mip count the sides allow.
            k = KIND_W'($urandom_range(0, 2));
            w = legal_side();
            h = legal_side();
            d = (k == KIND_VOLUME) ? legal_side() : SIDE_W'(1);
            rest     = w | h | d;
            halvings = 0;
            while (rest != '0)
            begin
                halvings++;
                rest = rest >> 1;
            end
            issue_request(k, FMT_W'($urandom), w, h, d,
                          LVL_W'($urandom_range(1, halvings)));
        end
        else
        begin
            issue_request(KIND_W'($urandom),
                          FMT_W'($urandom),
                          SIDE_W'($urandom_range(0, 32767) >> $urandom_range(0, 14)),
                          SIDE_W'($urandom_range(0, 32767) >> $urandom_range(0, 14)),
                          SIDE_W'($urandom_range(0, 32767) >> $urandom_range(0, 14)),
                          LVL_W'($urandom));
        end
    endtask

    initial
    begin
        int phase_idle[3];
        phase_idle  = '{0, 51, 9};
        idle_pct    = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_PLAIN;
        format_code = FMT_R8;
        width_px    = '0;
        height_px   = '0;
        depth_px    = '0;
        mip_count   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every format on odd sides below the block and PVRTC minimum extents.
        for (int f = 0; f < 16; f++)
        begin
            issue_request(KIND_W'(f % 3), FMT_W'(f), SIDE_W'(13), SIDE_W'(7),
                          (KIND_W'(f % 3) == KIND_VOLUME) ? SIDE_W'(5) : SIDE_W'(1),
                          LVL_W'(4));
        end
        issue_request(KIND_PLAIN, FMT_R8, SIDE_W'(1), SIDE_W'(1), SIDE_W'(1), LVL_W'(1));
        issue_request(KIND_VOLUME, FMT_P64, SIDE_W'(16384), SIDE_W'(16384), SIDE_W'(16384),
                      LVL_W'(15));
        // Largest sides on a cube: the total saturates.
        issue_request(KIND_CUBE, FMT_P64, SIDE_W'(32767), SIDE_W'(32767), SIDE_W'(32767),
                      LVL_W'(15));
        issue_request(KIND_PLAIN, FMT_BC1, SIDE_W'(0), SIDE_W'(5), SIDE_W'(1), LVL_W'(1));
        issue_request(KIND_VOLUME, FMT_P32A, SIDE_W'(8), SIDE_W'(8), SIDE_W'(0), LVL_W'(2));
        issue_request(KIND_CUBE, FMT_ETC1, SIDE_W'(64), SIDE_W'(64), SIDE_W'(1), LVL_W'(0));
        issue_request(KIND_PLAIN, FMT_DEPTH32, SIDE_W'(4), SIDE_W'(4), SIDE_W'(1), LVL_W'(5));
        issue_request(KIND_PLAIN, FMT_PVRTC2A, SIDE_W'(32), SIDE_W'(32), SIDE_W'(3), LVL_W'(3));
        issue_request(KIND_SPARE, FMT_BC3, SIDE_W'(100), SIDE_W'(60), SIDE_W'(1), LVL_W'(7));
        issue_request(KIND_PLAIN, FMT_PVRTC4B, SIDE_W'(16385), SIDE_W'(2), SIDE_W'(1),
                      LVL_W'(15));

        for (int p = 0; p < 3; p++)
        begin
            idle_pct = phase_idle[p];
            repeat (PHASE_REQUESTS) random_request();
        end
        start <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
